FILE: hdl/pss_pkg.sv
// pss_pkg: shared types, constants and codes for the polyline segment snap block.
// No dependencies; imported by every module of the block.
package pss_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int Q14_SHIFT        = 14;
  localparam int DIST_W           = 30;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CFG_VERTEX_COUNT = 2'd0,
    CFG_DIR_TOL      = 2'd1,
    CFG_MAX_DIST     = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MODE_BEHIND,
    MODE_PAST,
    MODE_ON
  } mode_t;

  typedef struct packed {
    logic               operation;
    logic [5:0]         vertex_index;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic [19:0]        seg_length;
  } in_t;

  typedef struct packed {
    logic               found;
    logic [5:0]         segment_index;
    logic [24:0]        distance;
    logic signed [23:0] snap_x;
    logic signed [23:0] snap_y;
  } out_t;

  // one table row
  typedef struct packed {
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [19:0]        len;
  } vtx_t;

  typedef struct packed {
    logic start;  // query taken: clear walk state
    logic load;   // table write
    logic rd;     // issue next table read
    logic fin;    // move best match to output register
  } cmd_t;

  typedef struct packed {
    logic last;      // final read being issued
    logic few;       // fewer than two vertices
    logic empty;     // walk pipeline holds nothing
    logic out_busy;  // output register full and not being taken
  } sts_t;

endpackage

FILE: hdl/pss_ctrl.sv
// pss_ctrl: sequencer for loads and segment walks.
// Depends on pss_pkg; drives pss_dp through cmd_t, reads sts_t.
module pss_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_op,
  output logic          in_stall,
  output pss_pkg::cmd_t cmd,
  input  pss_pkg::sts_t sts
);
  import pss_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = sts.few ? ST_DONE : ST_WALK;
          end
        end
      end
      ST_WALK: begin
        cmd.rd = 1'b1;
        if (sts.last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts.empty) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: hdl/pss_dp.sv
// pss_dp: vertex table, five-stage segment scoring pipeline, best match and output register.
// Depends on pss_pkg; controlled by pss_ctrl.
module pss_dp #(
  parameter int MAX_VERTICES = pss_pkg::MAX_VERTICES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pss_pkg::cmd_t      cmd,
  output pss_pkg::sts_t      sts,
  input  pss_pkg::in_t       in_data,
  input  logic [6:0]         vertex_count,
  input  logic signed [15:0] dir_tol,
  input  logic [23:0]        max_dist,
  input  logic               out_stall,
  output logic               out_valid,
  output pss_pkg::out_t      out_data
);
  import pss_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  vtx_t mem [MAX_VERTICES];

  // query
  logic signed [23:0] qx_r, qy_r;
  logic signed [15:0] hx_r, hy_r;

  logic [CW-1:0] cnt;
  logic [CW-1:0] addr_r, addr_nxt;

  assign cnt = (32'(vertex_count) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vertex_count);

  // read stage
  vtx_t          cur_r, prev_r;
  logic          v0_r;
  logic [AW-1:0] k0_r;

  // stage 1
  logic               s1_v_r, s1_ok_r;
  logic [AW-1:0]      s1_i_r;
  logic signed [24:0] s1_lx_r, s1_ly_r, s1_ex_r, s1_ey_r;
  logic signed [15:0] s1_dx_r, s1_dy_r;
  logic [19:0]        s1_len_r;
  // stage 2
  logic               s2_v_r, s2_ok_r;
  logic [AW-1:0]      s2_i_r;
  logic signed [41:0] s2_a_r, s2_c_r;
  logic signed [24:0] s2_ex_r, s2_ey_r;
  logic signed [15:0] s2_dx_r, s2_dy_r;
  logic [19:0]        s2_len_r;
  // stage 3
  logic               s3_v_r, s3_ok_r;
  logic [AW-1:0]      s3_i_r;
  logic [DIST_W-1:0]  s3_d_r;
  mode_t              s3_m_r;
  logic [27:0]        s3_al_r;
  logic signed [24:0] s3_ex_r, s3_ey_r;
  logic signed [15:0] s3_dx_r, s3_dy_r;
  // stage 4
  logic               s4_v_r, s4_ok_r;
  logic [AW-1:0]      s4_i_r;
  logic [DIST_W-1:0]  s4_d_r;
  mode_t              s4_m_r;
  logic signed [44:0] s4_px_r, s4_py_r;
  logic signed [24:0] s4_ex_r, s4_ey_r;
  // best
  logic               bf_r;
  logic [AW-1:0]      bi_r;
  logic [DIST_W-1:0]  bd_r;
  logic signed [23:0] bsx_r, bsy_r;

  out_t out_r;
  logic out_v_r;

  // table
  always_ff @(posedge clk) begin
    if (cmd.load && (32'(in_data.vertex_index) < MAX_VERTICES)) begin
      mem[AW'(in_data.vertex_index)] <= '{in_data.pos_x, in_data.pos_y, in_data.vec_x,
                                          in_data.vec_y, in_data.seg_length};
    end
    if (cmd.rd) cur_r <= mem[addr_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qx_r <= in_data.pos_x;
      qy_r <= in_data.pos_y;
      hx_r <= in_data.vec_x;
      hy_r <= in_data.vec_y;
    end
  end

  always_comb begin
    addr_nxt = addr_r;
    if (cmd.start)   addr_nxt = '0;
    else if (cmd.rd) addr_nxt = addr_r + CW'(1);
  end

  assign sts.last     = (addr_r == cnt - CW'(1));
  assign sts.few      = (cnt < CW'(2));
  assign sts.empty    = !(v0_r || s1_v_r || s2_v_r || s3_v_r || s4_v_r);
  assign sts.out_busy = out_v_r && out_stall;

  // stage 1: offset from segment start and heading test
  logic signed [32:0] hd;
  logic signed [32:0] tol_w;
  assign hd    = 33'(hx_r) * 33'(prev_r.dx) + 33'(hy_r) * 33'(prev_r.dy);
  assign tol_w = 33'($signed({dir_tol, 14'd0}));

  // stage 3: scoring
  logic [41:0] c_abs, a_neg;
  logic [27:0] perp, back, al;
  always_comb begin
    c_abs = s2_c_r[41] ? 42'(-s2_c_r) : 42'(s2_c_r);
    a_neg = 42'(-s2_a_r);
    perp  = c_abs[41:14];
    back  = a_neg[41:14];
    al    = s2_a_r[41:14];
  end

  // stage 5: snap rounding toward zero, saturation, compare
  logic signed [44:0] rx, ry;
  logic signed [30:0] qsx, qsy;
  logic signed [23:0] snx, sny;

  function automatic logic signed [23:0] sat24(input logic signed [30:0] v);
    if (v > 31'sd8388607)       return 24'sh7FFFFF;
    else if (v < -31'sd8388608) return 24'sh800000;
    else                        return 24'(v);
  endfunction

  always_comb begin
    rx  = s4_px_r[44] ? s4_px_r + 45'sd16383 : s4_px_r;
    ry  = s4_py_r[44] ? s4_py_r + 45'sd16383 : s4_py_r;
    qsx = 31'(rx >>> Q14_SHIFT);
    qsy = 31'(ry >>> Q14_SHIFT);
    unique case (s4_m_r)
      MODE_BEHIND: begin
        snx = '0;
        sny = '0;
      end
      MODE_PAST: begin
        snx = sat24(31'(s4_ex_r));
        sny = sat24(31'(s4_ey_r));
      end
      default: begin
        snx = sat24(qsx);
        sny = sat24(qsy);
      end
    endcase
  end

  logic win;
  assign win = s4_v_r && s4_ok_r && (s4_d_r < DIST_W'(max_dist)) && (!bf_r || s4_d_r < bd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r  <= '0;
      v0_r    <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      bf_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      addr_r <= addr_nxt;
      v0_r   <= cmd.rd;
      s1_v_r <= v0_r && (k0_r != '0);
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      if (cmd.start)   bf_r <= 1'b0;
      else if (win)    bf_r <= 1'b1;
      if (cmd.fin)           out_v_r <= 1'b1;
      else if (!out_stall)   out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    k0_r <= addr_r[AW-1:0];
    if (v0_r) prev_r <= cur_r;
    // stage 1
    s1_i_r   <= k0_r - AW'(1);
    s1_ok_r  <= !(hd < tol_w);
    s1_lx_r  <= 25'(qx_r) - 25'(prev_r.vx);
    s1_ly_r  <= 25'(qy_r) - 25'(prev_r.vy);
    s1_ex_r  <= 25'(cur_r.vx) - 25'(prev_r.vx);
    s1_ey_r  <= 25'(cur_r.vy) - 25'(prev_r.vy);
    s1_dx_r  <= prev_r.dx;
    s1_dy_r  <= prev_r.dy;
    s1_len_r <= prev_r.len;
    // stage 2
    s2_i_r   <= s1_i_r;
    s2_ok_r  <= s1_ok_r;
    s2_a_r   <= 42'(s1_lx_r) * 42'(s1_dx_r) + 42'(s1_ly_r) * 42'(s1_dy_r);
    s2_c_r   <= 42'(s1_lx_r) * 42'(s1_dy_r) - 42'(s1_ly_r) * 42'(s1_dx_r);
    s2_ex_r  <= s1_ex_r;
    s2_ey_r  <= s1_ey_r;
    s2_dx_r  <= s1_dx_r;
    s2_dy_r  <= s1_dy_r;
    s2_len_r <= s1_len_r;
    // stage 3
    s3_i_r  <= s2_i_r;
    s3_ok_r <= s2_ok_r;
    s3_al_r <= al;
    s3_ex_r <= s2_ex_r;
    s3_ey_r <= s2_ey_r;
    s3_dx_r <= s2_dx_r;
    s3_dy_r <= s2_dy_r;
    priority if (s2_a_r < 0) begin
      s3_m_r <= MODE_BEHIND;
      s3_d_r <= DIST_W'(perp) + DIST_W'(back);
    end else if (al > 28'(s2_len_r)) begin
      s3_m_r <= MODE_PAST;
      s3_d_r <= DIST_W'(perp) + DIST_W'(al) - DIST_W'(s2_len_r);
    end else begin
      s3_m_r <= MODE_ON;
      s3_d_r <= DIST_W'(perp);
    end
    // stage 4
    s4_i_r  <= s3_i_r;
    s4_ok_r <= s3_ok_r;
    s4_d_r  <= s3_d_r;
    s4_m_r  <= s3_m_r;
    s4_ex_r <= s3_ex_r;
    s4_ey_r <= s3_ey_r;
    s4_px_r <= 45'(s3_dx_r) * 45'($signed({1'b0, s3_al_r}));
    s4_py_r <= 45'(s3_dy_r) * 45'($signed({1'b0, s3_al_r}));
    // best
    if (win) begin
      bi_r  <= s4_i_r;
      bd_r  <= s4_d_r;
      bsx_r <= snx;
      bsy_r <= sny;
    end
    if (cmd.fin) begin
      if (bf_r) begin
        out_r.found         <= 1'b1;
        out_r.segment_index <= 6'(bi_r);
        out_r.distance      <= (bd_r > DIST_W'(33554431)) ? '1 : bd_r[24:0];
        out_r.snap_x        <= bsx_r;
        out_r.snap_y        <= bsy_r;
      end else begin
        out_r.found         <= 1'b0;
        out_r.segment_index <= '0;
        out_r.distance      <= '1;
        out_r.snap_x        <= '0;
        out_r.snap_y        <= '0;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

FILE: hdl/polyline_segment_snap.sv
// polyline_segment_snap: snaps a query position onto a stored polyline.
// A load writes one table row; a query reads the table once per vertex, then the five-stage
// scoring pipeline drains and the best match moves to the output register; with fewer than
// two vertices the walk is skipped and a miss goes straight to the output register.
// Throughput: one query at a time, set by the single table read port walking the vertices;
// a stalled result holds back the next query. Reset (rst_n, synchronous): controller idle,
// output empty, count 0, tolerance 0, maximum distance 500; the vertex table is not cleared.
module polyline_segment_snap #(
  parameter int MAX_VERTICES = pss_pkg::MAX_VERTICES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  pss_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output pss_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [23:0]   cfg_wdata
);
  import pss_pkg::*;

  logic [6:0]         vcount_r;
  logic signed [15:0] tol_r;
  logic [23:0]        maxd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
      tol_r    <= '0;
      maxd_r   <= 24'd500;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERTEX_COUNT: vcount_r <= cfg_wdata[6:0];
        CFG_DIR_TOL:      tol_r    <= cfg_wdata[15:0];
        CFG_MAX_DIST:     maxd_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  cmd_t cmd;
  sts_t sts;

  pss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  pss_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_data      (in_data),
    .vertex_count (vcount_r),
    .dir_tol      (tol_r),
    .max_dist     (maxd_r),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_data     (out_data)
  );

  // a miss always reports the saturated distance and a zero snap
  a_miss_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.distance == '1 && out_data.snap_x == '0
      && out_data.snap_y == '0)
    else $error("miss result not in canonical form");

  // an accepted query keeps the input side busy on the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.operation == OP_QUERY |=> in_stall)
    else $error("input taken while a query walks");

  // a hit lies under the distance limit
  a_hit_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.distance < 25'(maxd_r))
    else $error("hit at or beyond maximum distance");

endmodule
